>>> hw/rtl/icrc_pkg.sv
// ----------------------------------------------------------------------------
// icrc_pkg: shared types, constants and functions
// This file holds the register indexes, the type-code helpers and the bound
// struct that the range check uses.
// ----------------------------------------------------------------------------
`default_nettype none

package icrc_pkg;

    localparam int ELEM_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int TYPE_W = 3;

    localparam logic [ELEM_W-1:0] SIGN_BIT = {1'b1, {(ELEM_W-1){1'b0}}};

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_TYPE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TYPE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND = 3'd4;

    // width codes, low two bits of a type code
    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;
    localparam logic [1:0] WC_32 = 2'd2;
    localparam logic [1:0] WC_64 = 2'd3;

    typedef struct packed {
        logic [1:0]        width_code;
        logic              col_signed;
        logic [ELEM_W-1:0] lo_key;
        logic [ELEM_W-1:0] hi_key;
    } t_check_cfg;

    function automatic logic [ELEM_W-1:0] f_mask(input logic [1:0] wc);
        logic [ELEM_W-1:0] m;
        case (wc)
            WC_8:    m = {{(ELEM_W-8){1'b0}}, {8{1'b1}}};
            WC_16:   m = {{(ELEM_W-16){1'b0}}, {16{1'b1}}};
            WC_32:   m = {{(ELEM_W-32){1'b0}}, {32{1'b1}}};
            default: m = {ELEM_W{1'b1}};
        endcase
        return m;
    endfunction

    function automatic logic f_top_bit(input logic [ELEM_W-1:0] bits,
                                       input logic [1:0] wc);
        logic b;
        case (wc)
            WC_8:    b = bits[7];
            WC_16:   b = bits[15];
            WC_32:   b = bits[31];
            default: b = bits[ELEM_W-1];
        endcase
        return b;
    endfunction

    function automatic logic [ELEM_W-1:0] f_extend(input logic [ELEM_W-1:0] bits,
                                                   input logic [1:0] wc,
                                                   input logic sg);
        logic [ELEM_W-1:0] m;
        logic [ELEM_W-1:0] v;
        m = f_mask(wc);
        v = bits & m;
        if (sg && f_top_bit(bits, wc)) begin
            v = v | ~m;
        end
        return v;
    endfunction

    function automatic logic f_type_signed(input logic [TYPE_W-1:0] t);
        return ~t[2];
    endfunction

    function automatic logic [ELEM_W-1:0] f_type_max(input logic [TYPE_W-1:0] t);
        logic [ELEM_W-1:0] m;
        m = f_mask(t[1:0]);
        return f_type_signed(t) ? (m >> 1) : m;
    endfunction

    // order-preserving unsigned key
    function automatic logic [ELEM_W-1:0] f_key(input logic [ELEM_W-1:0] v,
                                                input logic sg);
        return sg ? (v ^ SIGN_BIT) : v;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/icrc_in_if.sv
// ----------------------------------------------------------------------------
// icrc_in_if: element channel
// Valid/ready channel that carries one column element per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface icrc_in_if;
    import icrc_pkg::*;

    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] element_bits;
    logic              element_valid;
    logic              last_element;

    modport source (
        output valid,
        output element_bits,
        output element_valid,
        output last_element,
        input  ready
    );

    modport sink (
        input  valid,
        input  element_bits,
        input  element_valid,
        input  last_element,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/icrc_out_if.sv
// ----------------------------------------------------------------------------
// icrc_out_if: result channel
// Valid/ready channel that carries the per-column check result.
// ----------------------------------------------------------------------------
`default_nettype none

interface icrc_out_if;
    import icrc_pkg::*;

    logic              valid;
    logic              ready;
    logic              check_status;
    logic [ELEM_W-1:0] offending_value;

    modport source (
        output valid,
        output check_status,
        output offending_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  check_status,
        input  offending_value,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/integer_cast_range_check.sv
// ----------------------------------------------------------------------------
// integer_cast_range_check: streaming range check of an integer column
// Channels: i_item carries one column element per item (raw bits, a present
//   flag and an end-of-column flag); o_result carries one item per column
//   with the status and the first out-of-range element.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write one register per
//   cycle: bound mode, column type, target type, lower and upper bound.
// Throughput: one item per cycle while no last item waits on a pending
//   result; the compare sits between the element register and the result
//   register, so nothing else limits the rate below that.
// Path: a last item goes through the element register, then the result register.
// Stall: while a result waits on o_result, non-last items still flow in and
//   update the column state; a following last item holds in the element
//   register, and i_item.ready drops, until the result is taken.
// Reset: synchronous, active low; registers return to derived mode with
//   signed 64-bit column and target types, bounds zero, no pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_cast_range_check (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [icrc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [icrc_pkg::ELEM_W-1:0]    i_cfg_data,
    icrc_in_if.sink                             i_item,
    icrc_out_if.source                          o_result
);
    import icrc_pkg::*;

    t_check_cfg check_cfg;

    icrc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_check_cfg (check_cfg)
    );

    icrc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_check_cfg (check_cfg),
        .i_item      (i_item),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

>>> hw/rtl/icrc_cfg.sv
// ----------------------------------------------------------------------------
// icrc_cfg: configuration registers and bound selection
// Holds the five registers and turns them into the column width, signedness
// and the ordered lower and upper bound keys.
// ----------------------------------------------------------------------------
`default_nettype none

module icrc_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [icrc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [icrc_pkg::ELEM_W-1:0]    i_cfg_data,
    output icrc_pkg::t_check_cfg                o_check_cfg
);
    import icrc_pkg::*;

    logic              r_bound_mode;
    logic [TYPE_W-1:0] r_column_type;
    logic [TYPE_W-1:0] r_target_type;
    logic [ELEM_W-1:0] r_lower_bound;
    logic [ELEM_W-1:0] r_upper_bound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_mode  <= 1'b1;
            r_column_type <= 3'd3;
            r_target_type <= 3'd3;
            r_lower_bound <= '0;
            r_upper_bound <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BOUND_MODE:  r_bound_mode  <= i_cfg_data[0];
                REG_COLUMN_TYPE: r_column_type <= i_cfg_data[TYPE_W-1:0];
                REG_TARGET_TYPE: r_target_type <= i_cfg_data[TYPE_W-1:0];
                REG_LOWER_BOUND: r_lower_bound <= i_cfg_data;
                REG_UPPER_BOUND: r_upper_bound <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic              col_sg;
    logic              tgt_sg;
    logic [1:0]        min_wc;
    logic [ELEM_W-1:0] col_max;
    logic [ELEM_W-1:0] tgt_max;
    logic [ELEM_W-1:0] lo;
    logic [ELEM_W-1:0] hi;

    always_comb begin
        col_sg  = f_type_signed(r_column_type);
        tgt_sg  = f_type_signed(r_target_type);
        col_max = f_type_max(r_column_type);
        tgt_max = f_type_max(r_target_type);
        min_wc  = (r_column_type[1:0] < r_target_type[1:0]) ?
                  r_column_type[1:0] : r_target_type[1:0];
        if (r_bound_mode) begin
            // intersection of the column range and the target range
            hi = (col_max < tgt_max) ? col_max : tgt_max;
            lo = (col_sg && tgt_sg) ? ~(f_mask(min_wc) >> 1) : '0;
        end else begin
            lo = f_extend(r_lower_bound, r_column_type[1:0], col_sg);
            hi = f_extend(r_upper_bound, r_column_type[1:0], col_sg);
        end
        o_check_cfg.width_code = r_column_type[1:0];
        o_check_cfg.col_signed = col_sg;
        o_check_cfg.lo_key     = f_key(lo, col_sg);
        o_check_cfg.hi_key     = f_key(hi, col_sg);
    end

endmodule

`default_nettype wire

>>> hw/rtl/icrc_core.sv
// ----------------------------------------------------------------------------
// icrc_core: element register, range compare and result register
// Registers each item, compares it against the bound keys, keeps the first
// out-of-range element and loads the result register on the last element.
// ----------------------------------------------------------------------------
`default_nettype none

module icrc_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire icrc_pkg::t_check_cfg i_check_cfg,
    icrc_in_if.sink                   i_item,
    icrc_out_if.source                o_result
);
    import icrc_pkg::*;

    // element register
    logic              r_in_valid;
    logic [ELEM_W-1:0] r_in_bits;
    logic              r_in_ev;
    logic              r_in_last;

    // column state
    logic              r_err;
    logic [ELEM_W-1:0] r_bad;

    // result register
    logic              r_out_valid;
    logic              r_out_status;
    logic [ELEM_W-1:0] r_out_value;

    logic              adv;
    logic              in_fire;
    logic              out_fire;
    logic [ELEM_W-1:0] ext_val;
    logic [ELEM_W-1:0] val_key;
    logic              is_bad;
    logic              n_err;
    logic [ELEM_W-1:0] n_bad;

    // a last item waits only when the result register is full and stalled
    assign adv      = r_in_valid && (!r_in_last || !r_out_valid || o_result.ready);
    assign in_fire  = i_item.valid && i_item.ready;
    assign out_fire = r_out_valid && o_result.ready;

    assign i_item.ready = !r_in_valid || adv;

    always_comb begin
        ext_val = f_extend(r_in_bits, i_check_cfg.width_code, i_check_cfg.col_signed);
        val_key = f_key(ext_val, i_check_cfg.col_signed);
        is_bad  = r_in_ev && ((val_key < i_check_cfg.lo_key) ||
                              (val_key > i_check_cfg.hi_key));
        n_err   = r_err || is_bad;
        n_bad   = (is_bad && !r_err) ? (r_in_bits & f_mask(i_check_cfg.width_code))
                                     : r_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_bits <= i_item.element_bits;
            r_in_ev   <= i_item.element_valid;
            r_in_last <= i_item.last_element;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err       <= 1'b0;
            r_bad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv && r_in_last) begin
                r_err       <= 1'b0;
                r_bad       <= '0;
                r_out_valid <= 1'b1;
            end else begin
                if (adv) begin
                    r_err <= n_err;
                    r_bad <= n_bad;
                end
                if (out_fire) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out_status <= n_err;
            r_out_value  <= n_err ? n_bad : '0;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.check_status    = r_out_status;
    assign o_result.offending_value = r_out_value;

    a_bad_zero_when_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_err |-> (r_bad == '0))
        else $error("stored bad value without an error flag");

    a_last_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_last) |=> (!r_err && r_out_valid))
        else $error("last item did not close the column");

    a_ok_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_status) |-> (r_out_value == '0))
        else $error("clean result carries a nonzero value");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !(adv && r_in_last))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> sim/icrc_column_checker.sv
// ----------------------------------------------------------------------------
// icrc_column_checker: column range prediction and result compare
// Tracks the register writes and every accepted element, works out the
// status and first offending element of each column, and compares them
// field by field with the items taken from the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module icrc_column_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [icrc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [icrc_pkg::ELEM_W-1:0]    i_cfg_data,
    icrc_in_if                             item_ch,
    icrc_out_if                            result_ch,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_columns,
    output int                             o_flagged
);
    import icrc_pkg::*;

    typedef struct packed {
        logic              status;
        logic [ELEM_W-1:0] value;
    } t_column_verdict;

    t_column_verdict verdict_q[$];

    // register shadow
    logic              derive_bounds;
    logic [TYPE_W-1:0] col_t;
    logic [TYPE_W-1:0] tgt_t;
    logic [ELEM_W-1:0] lower_r;
    logic [ELEM_W-1:0] upper_r;

    // open column
    logic              bad_seen;
    logic [ELEM_W-1:0] bad_bits;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_columns = 0;
        o_flagged = 0;
    end

    function automatic logic [ELEM_W-1:0] ones_below(input int w);
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic logic [ELEM_W-1:0] widen(input logic [ELEM_W-1:0] raw,
                                                input int w, input logic sg);
        if (sg && raw[w-1]) begin
            return raw | ~ones_below(w);
        end
        return raw & ones_below(w);
    endfunction

    function automatic logic [ELEM_W-1:0] type_top(input logic [TYPE_W-1:0] t);
        int w;
        w = 8 << t[1:0];
        return t[2] ? ones_below(w) : ones_below(w - 1);
    endfunction

    function automatic logic outside_range(input logic [ELEM_W-1:0] raw);
        int                w;
        int                wt;
        logic              sg;
        logic [ELEM_W-1:0] v;
        logic [ELEM_W-1:0] lo;
        logic [ELEM_W-1:0] hi;
        logic [ELEM_W-1:0] cmax;
        logic [ELEM_W-1:0] tmax;
        w  = 8 << col_t[1:0];
        wt = 8 << tgt_t[1:0];
        sg = !col_t[2];
        v  = widen(raw, w, sg);
        if (derive_bounds) begin
            cmax = type_top(col_t);
            tmax = type_top(tgt_t);
            hi = (cmax < tmax) ? cmax : tmax;
            // negative side only survives when both types are signed
            lo = (sg && !tgt_t[2]) ? ~ones_below(((w < wt) ? w : wt) - 1) : '0;
        end else begin
            lo = widen(lower_r, w, sg);
            hi = widen(upper_r, w, sg);
        end
        if (sg) begin
            return ($signed(v) < $signed(lo)) || ($signed(v) > $signed(hi));
        end
        return (v < lo) || (v > hi);
    endfunction

    always @(posedge i_clk) begin
        t_column_verdict exp_v;
        if (!i_rst_n) begin
            derive_bounds = 1'b1;
            col_t    = {1'b0, WC_64};
            tgt_t    = {1'b0, WC_64};
            lower_r  = '0;
            upper_r  = '0;
            bad_seen = 1'b0;
            bad_bits = '0;
            verdict_q.delete();
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: result with none expected: status %0b value %h",
                             $time, result_ch.check_status, result_ch.offending_value);
                    o_errors++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (result_ch.check_status !== exp_v.status) begin
                        $display("%0t: check_status expected %0b actual %0b",
                                 $time, exp_v.status, result_ch.check_status);
                        o_errors++;
                    end
                    if (result_ch.offending_value !== exp_v.value) begin
                        $display("%0t: offending_value expected %h actual %h",
                                 $time, exp_v.value, result_ch.offending_value);
                        o_errors++;
                    end
                end
            end
            if (item_ch.valid && item_ch.ready) begin
                if (item_ch.element_valid && !bad_seen
                        && outside_range(item_ch.element_bits)) begin
                    bad_seen = 1'b1;
                    bad_bits = item_ch.element_bits & ones_below(8 << col_t[1:0]);
                end
                if (item_ch.last_element) begin
                    exp_v.status = bad_seen;
                    exp_v.value  = bad_seen ? bad_bits : '0;
                    verdict_q.push_back(exp_v);
                    o_columns++;
                    if (bad_seen) begin
                        o_flagged++;
                    end
                    bad_seen = 1'b0;
                    bad_bits = '0;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BOUND_MODE:  derive_bounds = i_cfg_data[0];
                    REG_COLUMN_TYPE: col_t = i_cfg_data[TYPE_W-1:0];
                    REG_TARGET_TYPE: tgt_t = i_cfg_data[TYPE_W-1:0];
                    REG_LOWER_BOUND: lower_r = i_cfg_data;
                    REG_UPPER_BOUND: upper_r = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

>>> sim/integer_cast_range_check_tb.sv
// ----------------------------------------------------------------------------
// integer_cast_range_check_tb: column range check testbench
// Drives columns of elements under many register settings, directed edge
// cases first and then random columns, with bursty input and a stalling
// result side. The column checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module integer_cast_range_check_tb;
    import icrc_pkg::*;

    // column and target type codes
    localparam logic [TYPE_W-1:0] T_S8  = 3'd0;
    localparam logic [TYPE_W-1:0] T_S16 = 3'd1;
    localparam logic [TYPE_W-1:0] T_S32 = 3'd2;
    localparam logic [TYPE_W-1:0] T_S64 = 3'd3;
    localparam logic [TYPE_W-1:0] T_U8  = 3'd4;
    localparam logic [TYPE_W-1:0] T_U16 = 3'd5;
    localparam logic [TYPE_W-1:0] T_U32 = 3'd6;
    localparam logic [TYPE_W-1:0] T_U64 = 3'd7;

    localparam int N_PHASES        = 24;
    localparam int ITEMS_PER_PHASE = 62;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int LONG_HOLD       = 80;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [ELEM_W-1:0]    i_cfg_data;

    icrc_in_if  elem_ch ();
    icrc_out_if result_ch ();

    int fail_count;
    int pending;
    int columns_done;
    int columns_flagged;

    // stimulus-side view of the registers, used to aim element values
    logic              cur_derive;
    logic [TYPE_W-1:0] cur_col;
    logic [TYPE_W-1:0] cur_tgt;
    logic [ELEM_W-1:0] cur_lower;
    logic [ELEM_W-1:0] cur_upper;

    int items_sent;
    int nulls_sent;
    int settings_used;
    int burst_left;
    int idle_cycles;

    integer_cast_range_check dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (elem_ch),
        .o_result   (result_ch)
    );

    icrc_column_checker checker_inst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .item_ch    (elem_ch),
        .result_ch  (result_ch),
        .o_errors   (fail_count),
        .o_pending  (pending),
        .o_columns  (columns_done),
        .o_flagged  (columns_flagged)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // nothing accepted for too long means the block is stuck
    always @(posedge i_clk) begin
        if ((elem_ch.valid && elem_ch.ready) || (result_ch.valid && result_ch.ready)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("[integer_cast_range_check] ERROR");
            $finish;
        end
    end

    // result side: random stall patterns, each kept for a random stretch,
    // plus one long hold while the sender keeps going
    initial begin : result_sink
        int  pattern;
        int  pattern_left;
        int  hold_left;
        bit  hold_done;
        pattern_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        pattern = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && items_sent >= 500) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern = $urandom_range(0, 3);
                    pattern_left = $urandom_range(16, 96);
                end
                pattern_left--;
                case (pattern)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= 1'($urandom_range(0, 1));
                    2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= ~result_ch.ready;
                endcase
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic [ELEM_W-1:0] bits, input logic present,
                             input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                elem_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        elem_ch.valid         <= 1'b1;
        elem_ch.element_bits  <= bits;
        elem_ch.element_valid <= present;
        elem_ch.last_element  <= last;
        do @(posedge i_clk); while (!elem_ch.ready);
        items_sent++;
        if (!present) begin
            nulls_sent++;
        end
        @(negedge i_clk);
    endtask

    // stop offering and wait until every result is out and the pipe is empty
    task automatic drain_block();
        elem_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ELEM_W-1:0] data);
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic write_settings(input logic derive, input logic [TYPE_W-1:0] col,
                                  input logic [TYPE_W-1:0] tgt,
                                  input logic [ELEM_W-1:0] lower,
                                  input logic [ELEM_W-1:0] upper);
        i_cfg_we <= 1'b1;
        put_reg(REG_BOUND_MODE, {63'd0, derive});
        put_reg(REG_COLUMN_TYPE, ELEM_W'(col));
        put_reg(REG_TARGET_TYPE, ELEM_W'(tgt));
        put_reg(REG_LOWER_BOUND, lower);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_UPPER_BOUND;
        i_cfg_data <= upper;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_derive = derive;
        cur_col    = col;
        cur_tgt    = tgt;
        cur_lower  = lower;
        cur_upper  = upper;
        settings_used++;
    endtask

    // element aimed at the current settings: mostly in range for a clean
    // column, otherwise type edges, bound edges and plain noise
    function automatic logic [ELEM_W-1:0] make_element(input logic clean);
        int                wc;
        int                wt;
        int                wn;
        logic [ELEM_W-1:0] ones_c;
        logic [ELEM_W-1:0] ones_t;
        logic [ELEM_W-1:0] span;
        logic [ELEM_W-1:0] v;
        int                pick;
        wc = 8 << cur_col[1:0];
        wt = 8 << cur_tgt[1:0];
        ones_c = (64'd1 << wc) - 64'd1;
        ones_t = (64'd1 << wt) - 64'd1;
        pick = (clean || $urandom_range(0, 9) >= 6) ? 4 : $urandom_range(0, 3);
        case (pick)
            0: v = {$urandom, $urandom};
            1: v = $urandom_range(0, 1) ? (cur_col[2] ? ones_c : ones_c >> 1)
                                        : (cur_col[2] ? 64'd0 : ~(ones_c >> 1));
            2: v = $urandom_range(0, 1) ? (cur_tgt[2] ? ones_t : ones_t >> 1)
                                        : (cur_tgt[2] ? 64'd0 : ~(ones_t >> 1));
            3: v = $urandom_range(0, 1) ? cur_lower : cur_upper;
            default: begin
                if (cur_derive) begin
                    wn = (wc < wt) ? wc : wt;
                    v = {$urandom, $urandom} & ((64'd1 << (wn - 1)) - 64'd1);
                    if (!cur_col[2] && !cur_tgt[2] && $urandom_range(0, 1)) begin
                        v = -v;
                    end
                end else begin
                    span = cur_upper - cur_lower;
                    v = (span == '1) ? {$urandom, $urandom}
                                     : cur_lower + ({$urandom, $urandom} % (span + 64'd1));
                end
            end
        endcase
        if (pick >= 1 && pick <= 3) begin
            v = v + 64'($urandom_range(0, 2)) - 64'd1;
        end
        // bits above the column width must not matter
        if (wc < 64 && $urandom_range(0, 1)) begin
            v = (v & ones_c) | ({$urandom, $urandom} & ~ones_c);
        end
        return v;
    endfunction

    initial begin : stimulus
        int                col_left;
        logic              col_clean;
        logic              derive;
        logic [TYPE_W-1:0] col;
        logic [TYPE_W-1:0] tgt;
        logic [ELEM_W-1:0] lower;
        logic [ELEM_W-1:0] upper;
        int                r;

        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_BOUND_MODE;
        i_cfg_data = '0;
        elem_ch.valid         = 1'b0;
        elem_ch.element_bits  = '0;
        elem_ch.element_valid = 1'b0;
        elem_ch.last_element  = 1'b0;
        idle_cycles   = 0;
        items_sent    = 0;
        nulls_sent    = 0;
        settings_used = 0;
        burst_left    = 0;
        col_left      = 0;
        col_clean     = 1'b0;
        cur_derive = 1'b1;
        cur_col    = T_S64;
        cur_tgt    = T_S64;
        cur_lower  = '0;
        cur_upper  = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: signed 64 to signed 64, full range passes
        send_item(64'h8000_0000_0000_0000, 1'b1, 1'b0);
        send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        send_item(64'h0, 1'b1, 1'b1);
        drain_block();

        // narrowing to signed 8, column closed by a null element
        write_settings(1'b1, T_S64, T_S8, '0, '0);
        send_item(64'd127, 1'b1, 1'b0);
        send_item(64'd128, 1'b1, 1'b0);
        send_item(64'hFFFF_FFFF_FFFF_FF80, 1'b1, 1'b0);
        send_item(64'hDEAD_BEEF_0000_1234, 1'b0, 1'b1);
        drain_block();

        // unsigned 64 into signed 64
        write_settings(1'b1, T_U64, T_S64, '0, '0);
        send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        send_item(64'h1, 1'b1, 1'b1);
        drain_block();

        // explicit bounds with junk above the column width: [-16, 16]
        write_settings(1'b0, T_S8, T_U8, 64'hABCD_1234_5678_9AF0, 64'h5555_AAAA_0000_0010);
        send_item(64'h0000_0000_0000_00F0, 1'b1, 1'b0);
        send_item(64'hFFFF_FFFF_FFFF_FF11, 1'b1, 1'b0);
        send_item(64'h0000_0000_0000_0010, 1'b1, 1'b1);
        drain_block();

        // empty range, then a column of nulls only
        write_settings(1'b0, T_U16, T_S32, 64'd5, 64'd3);
        send_item(64'd4, 1'b1, 1'b0);
        send_item(64'd4, 1'b1, 1'b1);
        send_item(64'hFFFF, 1'b0, 1'b0);
        send_item(64'h0, 1'b0, 1'b1);
        drain_block();

        // settings change in the middle of a column
        write_settings(1'b1, T_S32, T_U8, '0, '0);
        send_item(64'd200, 1'b1, 1'b0);
        drain_block();
        write_settings(1'b1, T_S32, T_S8, '0, '0);
        send_item(64'd200, 1'b1, 1'b1);
        drain_block();

        write_settings(1'b1, T_U8, T_U32, '0, '0);
        send_item(64'hFFFF_FFFF_FFFF_FF00, 1'b1, 1'b1);
        drain_block();
        write_settings(1'b1, T_S16, T_U16, '0, '0);
        send_item(64'h0000_0000_0000_8000, 1'b1, 1'b1);

        // random columns; a column may stay open across a settings change
        for (int phase = 0; phase < N_PHASES; phase++) begin
            drain_block();
            derive = 1'($urandom_range(0, 1));
            col    = 3'($urandom_range(0, 7));
            tgt    = 3'($urandom_range(0, 7));
            lower  = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: upper = lower + ({$urandom, $urandom} >> $urandom_range(0, 63));
                1: upper = lower - 64'd1 - ({$urandom, $urandom} >> $urandom_range(1, 63));
                2: upper = lower;
                default: upper = {$urandom, $urandom};
            endcase
            case (phase)
                0: write_settings(1'b1, T_S8, T_U64, lower, upper);
                1: write_settings(1'b1, T_U64, T_S8, lower, upper);
                2: write_settings(1'b0, T_U64, tgt, '0, '1);
                3: write_settings(1'b0, T_S8, tgt, '1, '0);
                4: write_settings(1'b0, T_S64, tgt, 64'h8000_0000_0000_0000,
                                  64'h7FFF_FFFF_FFFF_FFFF);
                5: write_settings(1'b1, T_U8, T_U8, '0, '1);
                6: write_settings(1'b0, T_U32, T_U16, lower, upper);
                default: write_settings(derive, col, tgt, lower, upper);
            endcase
            repeat (ITEMS_PER_PHASE) begin
                if (col_left == 0) begin
                    r = $urandom_range(0, 99);
                    col_left = (r < 70) ? $urandom_range(1, 6)
                             : (r < 95) ? $urandom_range(7, 20) : $urandom_range(30, 60);
                    col_clean = ($urandom_range(0, 9) < 4);
                end
                send_item(make_element(col_clean), ($urandom_range(0, 99) < 85),
                          (col_left == 1));
                col_left--;
            end
        end
        if (col_left > 0) begin
            send_item(make_element(1'b0), 1'b1, 1'b1);
        end

        drain_block();
        repeat (8) @(negedge i_clk);
        $display("covered %0d elements (%0d null) in %0d columns, %0d out of range,",
                 items_sent, nulls_sent, columns_done, columns_flagged);
        $display("over %0d register settings; %0d mismatches", settings_used, fail_count);
        if (fail_count == 0) begin
            $display("[integer_cast_range_check] OK");
        end else begin
            $display("[integer_cast_range_check] ERROR");
        end
        $finish;
    end

endmodule
